// ----- src/tkc_pkg.sv -----
// Shared types, constants and functions of the touch keypad calculator.
package tkc_pkg;

  localparam int unsigned EntryW = 30;
  localparam logic [EntryW-1:0] EntryLimit = 30'd999999999;
  localparam int unsigned DivSteps = EntryW;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_DIV  = 3'd1,
    OP_MUL  = 3'd2,
    OP_SUB  = 3'd3,
    OP_ADD  = 3'd4
  } op_t;

  localparam logic [3:0] KEY_CLEAR  = 4'd10;
  localparam logic [3:0] KEY_EQUALS = 4'd11;
  localparam logic [3:0] KEY_DIV    = 4'd12;
  localparam logic [3:0] KEY_MUL    = 4'd13;
  localparam logic [3:0] KEY_SUB    = 4'd14;
  localparam logic [3:0] KEY_ADD    = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_DIGIT,
    CMD_OPER,
    CMD_ARITH,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_DONE,
    CMD_CLEAR,
    CMD_EQ_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic      load;
    cmd_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic is_digit;
    logic is_oper;
    logic is_equals;
    logic op_valid;
    logic op_div;
  } dp_status_t;

  typedef struct packed {
    logic [9:0] x_lo;
    logic [9:0] x_hi;
    logic [9:0] y_lo;
    logic [9:0] y_hi;
    logic [3:0] key;
  } zone_t;

  function automatic zone_t zone_at(input logic [3:0] i);
    zone_t z;
    unique case (i)
      4'd0:  z = '{10'd70,  10'd285, 10'd100, 10'd262, 4'd0};
      4'd1:  z = '{10'd70,  10'd285, 10'd263, 10'd425, 4'd1};
      4'd2:  z = '{10'd285, 10'd500, 10'd263, 10'd425, 4'd2};
      4'd3:  z = '{10'd500, 10'd715, 10'd263, 10'd425, 4'd3};
      4'd4:  z = '{10'd70,  10'd285, 10'd425, 10'd587, 4'd4};
      4'd5:  z = '{10'd285, 10'd500, 10'd425, 10'd587, 4'd5};
      4'd6:  z = '{10'd500, 10'd715, 10'd425, 10'd587, 4'd6};
      4'd7:  z = '{10'd70,  10'd285, 10'd587, 10'd750, 4'd7};
      4'd8:  z = '{10'd285, 10'd500, 10'd587, 10'd750, 4'd8};
      4'd9:  z = '{10'd500, 10'd715, 10'd587, 10'd750, 4'd9};
      4'd10: z = '{10'd715, 10'd930, 10'd100, 10'd262, KEY_DIV};
      4'd11: z = '{10'd715, 10'd930, 10'd263, 10'd425, KEY_MUL};
      4'd12: z = '{10'd715, 10'd930, 10'd425, 10'd587, KEY_SUB};
      4'd13: z = '{10'd715, 10'd930, 10'd587, 10'd750, KEY_ADD};
      4'd14: z = '{10'd500, 10'd715, 10'd100, 10'd262, KEY_EQUALS};
      default: z = '{10'd285, 10'd500, 10'd100, 10'd262, KEY_CLEAR};
    endcase
    return z;
  endfunction

endpackage

// ----- src/tkc_if.sv -----
// Valid/ready channel interfaces for touch samples and calculator results.
interface tkc_touch_if;
  logic       valid;
  logic       ready;
  logic [9:0] touch_x;
  logic [9:0] touch_y;
  modport source (output valid, touch_x, touch_y, input ready);
  modport sink (input valid, touch_x, touch_y, output ready);
endinterface

interface tkc_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  key_code;
  logic        display_update;
  logic signed [31:0] display_value;
  logic        entry_overflow;
  logic        divide_by_zero;
  modport source (output valid, key_code, display_update, display_value, entry_overflow,
                  divide_by_zero, input ready);
  modport sink (input valid, key_code, display_update, display_value, entry_overflow,
                divide_by_zero, output ready);
endinterface

// ----- src/tkc_ctrl.sv -----
// Controller state machine sequencing decode, execute and division.
module tkc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tkc_pkg::dp_status_t status,
  output tkc_pkg::dp_cmd_t    cmd
);
  import tkc_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '{load: 1'b0, kind: CMD_NONE};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (!status.hit) begin
          state_nxt = ST_IDLE;
        end else if (status.is_digit) begin
          cmd.kind  = CMD_DIGIT;
          state_nxt = ST_OUTPUT;
        end else if (status.is_oper) begin
          cmd.kind  = CMD_OPER;
          state_nxt = ST_OUTPUT;
        end else if (status.is_equals) begin
          priority if (!status.op_valid) begin
            cmd.kind  = CMD_EQ_NOP;
            state_nxt = ST_OUTPUT;
          end else if (status.op_div) begin
            cmd.kind  = CMD_DIV_START;
            cnt_nxt   = '0;
            state_nxt = ST_DIVIDE;
          end else begin
            cmd.kind  = CMD_ARITH;
            state_nxt = ST_EXEC;
          end
        end else begin
          cmd.kind  = CMD_CLEAR;
          state_nxt = ST_OUTPUT;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_OUTPUT;
      end
      ST_DIVIDE: begin
        if (cnt_r == 6'(DivSteps)) begin
          cmd.kind  = CMD_DIV_DONE;
          state_nxt = ST_OUTPUT;
        end else begin
          cmd.kind = CMD_DIV_STEP;
          cnt_nxt  = cnt_r + 6'd1;
        end
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- src/tkc_dp.sv -----
// Datapath: key decode, entry and operand registers, multiplier and divider.
module tkc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tkc_pkg::dp_cmd_t    cmd,
  input  logic [9:0]          touch_x,
  input  logic [9:0]          touch_y,
  output tkc_pkg::dp_status_t status,
  output logic [3:0]          key_code,
  output logic                display_update,
  output logic [31:0]         display_value,
  output logic                entry_overflow,
  output logic                divide_by_zero
);
  import tkc_pkg::*;

  logic [9:0]        x_r, y_r;
  logic [EntryW-1:0] entry_r, entry_nxt;
  logic [EntryW-1:0] first_r, first_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [3:0]        key_r, key_nxt;
  logic              upd_r, upd_nxt, ovf_r, ovf_nxt, dz_r, dz_nxt;
  logic [31:0]       shown_r, shown_nxt;
  logic [EntryW-1:0] quo_r, quo_nxt;
  logic [EntryW:0]   rem_r, rem_nxt;
  logic              hit;
  logic [3:0]        key;
  logic [EntryW+3:0] digit_val;
  logic [59:0]       prod;
  logic [EntryW:0]   rem_shift;
  logic [EntryW:0]   rem_sub;

  always_comb begin
    zone_t z;
    hit = 1'b0;
    key = '0;
    for (int i = 15; i >= 0; i--) begin
      z = zone_at(4'(i));
      if (x_r >= z.x_lo && x_r <= z.x_hi && y_r >= z.y_lo && y_r < z.y_hi) begin
        hit = 1'b1;
        key = z.key;
      end
    end
  end

  assign status.hit       = hit;
  assign status.is_digit  = (key <= 4'd9);
  assign status.is_oper   = (key >= KEY_DIV);
  assign status.is_equals = (key == KEY_EQUALS);
  assign status.op_valid  = (op_r == OP_DIV) || (op_r == OP_MUL) || (op_r == OP_SUB) ||
                            (op_r == OP_ADD);
  assign status.op_div    = (op_r == OP_DIV);

  assign digit_val = {1'b0, entry_r, 3'b000} + {3'b000, entry_r, 1'b0} + {30'd0, key};
  assign prod      = entry_r * first_r;
  assign rem_shift = {rem_r[EntryW-1:0], quo_r[EntryW-1]};
  assign rem_sub   = rem_shift - {1'b0, entry_r};

  always_comb begin
    entry_nxt = entry_r;
    first_nxt = first_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    upd_nxt   = upd_r;
    ovf_nxt   = ovf_r;
    dz_nxt    = dz_r;
    shown_nxt = shown_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    unique case (cmd.kind)
      CMD_DIGIT: begin
        key_nxt = key;
        upd_nxt = 1'b1;
        dz_nxt  = 1'b0;
        if (digit_val > {4'd0, EntryLimit}) begin
          entry_nxt = '0;
          ovf_nxt   = 1'b1;
          shown_nxt = '0;
        end else begin
          entry_nxt = digit_val[EntryW-1:0];
          ovf_nxt   = 1'b0;
          shown_nxt = {2'b00, digit_val[EntryW-1:0]};
        end
      end
      CMD_OPER: begin
        key_nxt   = key;
        upd_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
        dz_nxt    = 1'b0;
        shown_nxt = '0;
        first_nxt = entry_r;
        entry_nxt = '0;
        unique case (key)
          KEY_DIV: op_nxt = OP_DIV;
          KEY_MUL: op_nxt = OP_MUL;
          KEY_SUB: op_nxt = OP_SUB;
          default: op_nxt = OP_ADD;
        endcase
      end
      CMD_ARITH: begin
        key_nxt = key;
        upd_nxt = 1'b1;
        ovf_nxt = 1'b0;
        dz_nxt  = 1'b0;
        unique case (op_r)
          OP_MUL:  shown_nxt = prod[31:0];
          OP_SUB:  shown_nxt = {2'b00, first_r} - {2'b00, entry_r};
          default: shown_nxt = {2'b00, first_r} + {2'b00, entry_r};
        endcase
        entry_nxt = '0;
        first_nxt = '0;
        op_nxt    = OP_NONE;
      end
      CMD_DIV_START: begin
        key_nxt = key;
        quo_nxt = first_r;
        rem_nxt = '0;
      end
      CMD_DIV_STEP: begin
        if (!rem_sub[EntryW]) begin
          rem_nxt = rem_sub;
          quo_nxt = {quo_r[EntryW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift;
          quo_nxt = {quo_r[EntryW-2:0], 1'b0};
        end
      end
      CMD_DIV_DONE: begin
        upd_nxt   = 1'b1;
        ovf_nxt   = 1'b0;
        dz_nxt    = (entry_r == '0);
        shown_nxt = (entry_r == '0) ? 32'd0 : {2'b00, quo_r};
        entry_nxt = '0;
        first_nxt = '0;
        op_nxt    = OP_NONE;
      end
      CMD_CLEAR: begin
        key_nxt   = key;
        upd_nxt   = 1'b1;
        ovf_nxt   = 1'b0;
        dz_nxt    = 1'b0;
        shown_nxt = '0;
        entry_nxt = '0;
        first_nxt = '0;
        op_nxt    = OP_NONE;
      end
      CMD_EQ_NOP: begin
        key_nxt   = key;
        upd_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
        dz_nxt    = 1'b0;
        shown_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      first_r <= '0;
      op_r    <= OP_NONE;
    end else begin
      entry_r <= entry_nxt;
      first_r <= first_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= touch_x;
      y_r <= touch_y;
    end
    key_r   <= key_nxt;
    upd_r   <= upd_nxt;
    ovf_r   <= ovf_nxt;
    dz_r    <= dz_nxt;
    shown_r <= shown_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
  end

  assign key_code       = key_r;
  assign display_update = upd_r;
  assign display_value  = shown_r;
  assign entry_overflow = ovf_r;
  assign divide_by_zero = dz_r;
endmodule

// ----- src/touch_keypad_calculator_unit.sv -----
// Top level of the touch keypad four-function calculator.
//
//   channel  direction  payload
//   in       sink       touch_x, touch_y
//   out      source     key_code, display_update, display_value, flags
//
// One sample at a time. A miss is dropped; a digit, operator or clear goes to output;
// add, subtract or multiply run execute; divide runs the one-bit-a-cycle divider.
// The result holds in registers until its transfer; no new sample is taken meanwhile.
// Synchronous active-low reset clears the entry, operand and pending operation.
module touch_keypad_calculator_unit (
  input logic         clk,
  input logic         rst_n,
  tkc_touch_if.sink   in_ch,
  tkc_result_if.source out_ch
);
  import tkc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [31:0] shown;

  tkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tkc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .touch_x        (in_ch.touch_x),
    .touch_y        (in_ch.touch_y),
    .status         (status),
    .key_code       (out_ch.key_code),
    .display_update (out_ch.display_update),
    .display_value  (shown),
    .entry_overflow (out_ch.entry_overflow),
    .divide_by_zero (out_ch.divide_by_zero)
  );

  assign out_ch.display_value = signed'(shown);
endmodule
